// ----- design/dla_pkg.sv -----
// ---------------------------------------------------------------------------
// dla_pkg: shared types and constants
// Payload structs, operation and register codes, and the exp(-t) step table.
// ---------------------------------------------------------------------------
package dla_pkg;

  localparam int IN_DIM_MAX  = 256;
  localparam int OUT_DIM_MAX = 32;
  localparam int DATA_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int ACC_W       = 42;
  localparam int ROW_W       = 8;
  localparam int COL_W       = 5;
  localparam int IN_CNT_W    = 9;
  localparam int OUT_CNT_W   = 6;
  localparam int EXP_STEPS   = 17;
  localparam int QUO_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_ELEM   = 2'd2;

  localparam logic [1:0] ACT_SIGMOID = 2'd0;
  localparam logic [1:0] ACT_TANH    = 2'd1;
  localparam logic [1:0] ACT_RELU    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_DIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_DIM = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [ROW_W-1:0]        weight_row;
    logic [COL_W-1:0]        feature_col;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] feature_value;
    logic [COL_W-1:0]        feature_index;
    logic                    last_feature;
  } out_item_t;

  typedef struct packed {
    logic                    mac_en;
    logic                    first;
    logic                    shift;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] elem;
    logic [ROW_W-1:0]        waddr;
    logic [ROW_W-1:0]        raddr;
  } cell_ctrl_t;

  typedef logic [31:0] exp_tab_t [EXP_STEPS];

  // exp(-2^k / 2^FRAC_BITS) in Q0.32, by repeated rounded squaring
  function automatic exp_tab_t exp_table();
    exp_tab_t    t;
    logic [63:0] b;
    b = 64'd4293918848;
    for (int i = 0; i < EXP_STEPS; i++) begin
      t[i] = b[31:0];
      b = (b * b + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

endpackage

// ----- design/dla_cell.sv -----
// ---------------------------------------------------------------------------
// dla_cell: one feature cell
// Weight column memory, bias word and accumulator; shifts toward cell 0.
// ---------------------------------------------------------------------------
module dla_cell (
  input  logic                              clk,
  input  dla_pkg::cell_ctrl_t               ctrl,
  input  logic                              wsel,
  input  logic                              bsel,
  input  logic signed [dla_pkg::ACC_W-1:0]  acc_in,
  output logic signed [dla_pkg::ACC_W-1:0]  acc_out
);

  logic signed [dla_pkg::DATA_W-1:0] wmem [dla_pkg::IN_DIM_MAX];
  logic signed [dla_pkg::DATA_W-1:0] w_q_r;
  logic signed [dla_pkg::DATA_W-1:0] bias_r;
  logic signed [dla_pkg::ACC_W-1:0]  acc_r, acc_nxt, acc_base;
  logic signed [2*dla_pkg::DATA_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (wsel) begin
      wmem[ctrl.waddr] <= ctrl.data;
    end
    w_q_r <= wmem[ctrl.raddr];
  end

  always_ff @(posedge clk) begin
    if (bsel) begin
      bias_r <= ctrl.data;
    end
  end

  always_comb begin
    prod     = ctrl.elem * w_q_r;
    acc_base = ctrl.first ? (dla_pkg::ACC_W'(bias_r) <<< dla_pkg::FRAC_BITS) : acc_r;
    acc_nxt  = acc_r;
    if (ctrl.shift) begin
      acc_nxt = acc_in;
    end else if (ctrl.mac_en) begin
      acc_nxt = acc_base + dla_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_out = acc_r;

endmodule

// ----- design/dla_act.sv -----
// ---------------------------------------------------------------------------
// dla_act: activation unit
// Round/saturate a sum, then sigmoid, tanh, ReLU or identity; output register.
// ---------------------------------------------------------------------------
module dla_act (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [dla_pkg::ACC_W-1:0]  acc,
  input  logic [1:0]                        mode,
  input  logic [dla_pkg::COL_W-1:0]         idx,
  input  logic                              last,
  output logic                              rdy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dla_pkg::out_item_t                out_data
);

  localparam dla_pkg::exp_tab_t EXP_TAB = dla_pkg::exp_table();
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [2:0] {A_IDLE, A_EXP, A_PREP, A_DIV, A_OUT} ast_t;

  ast_t                 st_r;
  logic                 tanh_r, neg_r, pos_r;
  logic [16:0]          a_r;
  logic [4:0]           k_r;
  logic [32:0]          res_r;
  logic [44:0]          rem_r;
  logic [45:0]          dsh_r;
  logic [dla_pkg::QUO_W-1:0] q_r;
  dla_pkg::out_item_t   ob_r;

  logic signed [dla_pkg::ACC_W:0] t_sum, t_sh;
  logic signed [dla_pkg::DATA_W-1:0] v;
  logic [16:0]          v_abs;
  logic [64:0]          prod, prod_rnd;
  logic [33:0]          den;
  logic [32:0]          num;
  logic                 q_ge;
  logic [dla_pkg::QUO_W-1:0] q_nxt;
  logic signed [dla_pkg::DATA_W-1:0] q_val;

  always_comb begin
    t_sum = {acc[dla_pkg::ACC_W-1], acc} + (dla_pkg::ACC_W+1)'(2048);
    t_sh  = t_sum >>> dla_pkg::FRAC_BITS;
    if (t_sh > (dla_pkg::ACC_W+1)'(32767)) begin
      v = 16'sh7fff;
    end else if (t_sh < -(dla_pkg::ACC_W+1)'(32768)) begin
      v = 16'sh8000;
    end else begin
      v = t_sh[dla_pkg::DATA_W-1:0];
    end
    v_abs    = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
    prod     = {32'd0, res_r} * {33'd0, EXP_TAB[k_r]};
    prod_rnd = prod + 65'h8000_0000;
    den      = {1'b0, ONE_Q32} + {1'b0, res_r};
    if (tanh_r) begin
      num = ONE_Q32 - res_r;
    end else begin
      num = pos_r ? ONE_Q32 : res_r;
    end
    q_ge  = ({1'b0, rem_r} >= dsh_r);
    q_nxt = {q_r[dla_pkg::QUO_W-2:0], q_ge};
    q_val = (tanh_r && neg_r) ? -dla_pkg::DATA_W'(q_nxt) : dla_pkg::DATA_W'(q_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      case (st_r)
        A_IDLE: begin
          if (start) begin
            ob_r.feature_index <= idx;
            ob_r.last_feature  <= last;
            tanh_r <= (mode == dla_pkg::ACT_TANH);
            neg_r  <= v[15];
            pos_r  <= !v[15] && (v != 16'sd0);
            res_r  <= ONE_Q32;
            k_r    <= 5'd0;
            case (mode)
              dla_pkg::ACT_SIGMOID: begin
                a_r  <= v_abs;
                st_r <= A_EXP;
              end
              dla_pkg::ACT_TANH: begin
                a_r  <= v_abs << 1;
                st_r <= A_EXP;
              end
              dla_pkg::ACT_RELU: begin
                ob_r.feature_value <= v[15] ? 16'sd0 : v;
                st_r <= A_OUT;
              end
              default: begin
                ob_r.feature_value <= v;
                st_r <= A_OUT;
              end
            endcase
          end
        end
        A_EXP: begin
          if (a_r[k_r]) begin
            res_r <= prod_rnd[64:32];
          end
          k_r <= k_r + 5'd1;
          if (k_r == 5'(dla_pkg::EXP_STEPS - 1)) begin
            st_r <= A_PREP;
          end
        end
        A_PREP: begin
          rem_r <= ({12'd0, num} << dla_pkg::FRAC_BITS) + {12'd0, den[33:1]};
          dsh_r <= {12'd0, den} << dla_pkg::FRAC_BITS;
          q_r   <= '0;
          k_r   <= 5'd0;
          st_r  <= A_DIV;
        end
        A_DIV: begin
          if (q_ge) begin
            rem_r <= rem_r - dsh_r[44:0];
          end
          q_r   <= q_nxt;
          dsh_r <= dsh_r >> 1;
          k_r   <= k_r + 5'd1;
          if (k_r == 5'(dla_pkg::QUO_W - 1)) begin
            st_r <= A_OUT;
            ob_r.feature_value <= q_val;
          end
        end
        A_OUT: begin
          if (out_ready) begin
            st_r <= A_IDLE;
          end
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign rdy       = (st_r == A_IDLE);
  assign out_valid = (st_r == A_OUT);
  assign out_data  = ob_r;

endmodule

// ----- design/dense_layer_activation_core.sv -----
// ---------------------------------------------------------------------------
// dense_layer_activation_core: random-feature hidden layer
// Chain of 32 MAC cells with per-cell weight memories, then one activation unit.
// ---------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_data (in_item_t)
// out     | out | out_valid/out_ready| out_data (out_item_t)
// cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// Loads and sample elements transfer one per cycle while in_ready is high; each
// element is registered with its weight read, then accumulated in every cell.
// After the last element, each feature passes through the shared activation
// unit (17 exp steps, 13 divide steps; ReLU skips both); inputs stall until
// every feature has entered the unit. Reset clears control state only.
// ---------------------------------------------------------------------------
module dense_layer_activation_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dla_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dla_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [dla_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dla_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic {S_RUN, S_EMIT} st_t;

  st_t                              state_r;
  logic [dla_pkg::ROW_W-1:0]        cnt_r;
  logic                             pend_r, mac_r, first_r;
  logic signed [dla_pkg::DATA_W-1:0] elem_r;
  logic [1:0]                       mode_r;
  logic [dla_pkg::IN_CNT_W-1:0]     in_dim_r, in_dim_eff, cnt_inc;
  logic [dla_pkg::OUT_CNT_W-1:0]    out_dim_r, out_dim_eff;
  logic [dla_pkg::COL_W-1:0]        eidx_r;
  logic                             accept, is_elem, done, start, last, act_rdy;
  dla_pkg::cell_ctrl_t              ctrl;
  logic [dla_pkg::OUT_DIM_MAX-1:0]  wsel, bsel;
  logic signed [dla_pkg::ACC_W-1:0] acc [dla_pkg::OUT_DIM_MAX+1];

  assign in_ready = (state_r == S_RUN) && !pend_r;
  assign accept   = in_valid && in_ready;
  assign is_elem  = accept && (in_data.operation == dla_pkg::OP_ELEM);

  always_comb begin
    if (in_dim_r == '0) begin
      in_dim_eff = dla_pkg::IN_CNT_W'(1);
    end else if (in_dim_r > dla_pkg::IN_CNT_W'(dla_pkg::IN_DIM_MAX)) begin
      in_dim_eff = dla_pkg::IN_CNT_W'(dla_pkg::IN_DIM_MAX);
    end else begin
      in_dim_eff = in_dim_r;
    end
    if (out_dim_r == '0) begin
      out_dim_eff = dla_pkg::OUT_CNT_W'(1);
    end else if (out_dim_r > dla_pkg::OUT_CNT_W'(dla_pkg::OUT_DIM_MAX)) begin
      out_dim_eff = dla_pkg::OUT_CNT_W'(dla_pkg::OUT_DIM_MAX);
    end else begin
      out_dim_eff = out_dim_r;
    end
    cnt_inc = {1'b0, cnt_r} + dla_pkg::IN_CNT_W'(1);
    done    = cnt_inc >= in_dim_eff;
    start   = (state_r == S_EMIT) && act_rdy;
    last    = ({1'b0, eidx_r} + dla_pkg::OUT_CNT_W'(1)) == out_dim_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= dla_pkg::ACT_SIGMOID;
      in_dim_r  <= dla_pkg::IN_CNT_W'(dla_pkg::IN_DIM_MAX);
      out_dim_r <= dla_pkg::OUT_CNT_W'(dla_pkg::OUT_DIM_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        dla_pkg::CFG_MODE:    mode_r    <= cfg_data[1:0];
        dla_pkg::CFG_IN_DIM:  in_dim_r  <= cfg_data;
        dla_pkg::CFG_OUT_DIM: out_dim_r <= cfg_data[dla_pkg::OUT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      mac_r   <= 1'b0;
      first_r <= 1'b0;
      eidx_r  <= '0;
    end else begin
      mac_r <= is_elem;
      if (is_elem) begin
        first_r <= (cnt_r == '0);
        elem_r  <= in_data.data_value;
        cnt_r   <= done ? '0 : cnt_inc[dla_pkg::ROW_W-1:0];
        pend_r  <= done;
      end
      if (pend_r) begin
        pend_r  <= 1'b0;
        state_r <= S_EMIT;
        eidx_r  <= '0;
      end
      if (start) begin
        eidx_r <= eidx_r + dla_pkg::COL_W'(1);
        if (last) begin
          state_r <= S_RUN;
        end
      end
    end
  end

  always_comb begin
    ctrl.mac_en = mac_r;
    ctrl.first  = first_r;
    ctrl.shift  = start;
    ctrl.data   = in_data.data_value;
    ctrl.elem   = elem_r;
    ctrl.waddr  = in_data.weight_row;
    ctrl.raddr  = cnt_r;
  end

  assign acc[dla_pkg::OUT_DIM_MAX] = '0;

  for (genvar j = 0; j < dla_pkg::OUT_DIM_MAX; j++) begin : g_cell
    assign wsel[j] = accept && (in_data.operation == dla_pkg::OP_WEIGHT) &&
                     (in_data.feature_col == dla_pkg::COL_W'(j));
    assign bsel[j] = accept && (in_data.operation == dla_pkg::OP_BIAS) &&
                     (in_data.feature_col == dla_pkg::COL_W'(j));
    dla_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wsel    (wsel[j]),
      .bsel    (bsel[j]),
      .acc_in  (acc[j+1]),
      .acc_out (acc[j])
    );
  end

  dla_act u_act (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .acc       (acc[0]),
    .mode      (mode_r),
    .idx       (eidx_r),
    .last      (last),
    .rdy       (act_rdy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !in_ready) else $error("input ready during emission");
  a_pend_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> state_r == S_EMIT) else $error("sample end did not start emission");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> act_rdy && !out_valid) else $error("activation start while busy");

endmodule
